/* src/lnr_pkg.sv */
// Shared constants and sequencer state type for the layer normalization block.
package lnr_pkg;

    localparam int MAX_LEN   = 64;
    localparam int ADDR_W    = 6;
    localparam int LEN_W     = 7;
    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int DIV_W     = 49;
    localparam int SQRT_W    = 32;

    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_EPSILON    = 1'b1;

    localparam logic CMD_ENTRY  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic signed [DATA_W-1:0] SCALE_ONE = 16'sd256;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_VAR_RD,
        ST_VAR_D,
        ST_VAR_SQ,
        ST_VAR_ACC,
        ST_EPS,
        ST_QADD,
        ST_QL,
        ST_SQRT,
        ST_OUT_RD,
        ST_OUT_D,
        ST_OUT_M1,
        ST_OUT_M2,
        ST_OUT_PREP,
        ST_OUT_GO,
        ST_OUT_WAIT,
        ST_OUT_PUT
    } lnr_state_t;

endpackage

/* src/layer_normalization_row.sv */
// Top level: row layer normalization with a sequencer over shared arithmetic.
//
//   channel | signals                                          | direction
//   config  | cfg_we, cfg_index, cfg_data                      | in
//   input   | in_valid/in_stall, command, entry_index,         | in
//           | sample_value, scale_value, shift_value           |
//   output  | out_valid/out_stall, normalized_value, position, | out
//           | row_end                                          |
//
// A table write or a sample that does not end a row is accepted without a stall.
// The last sample of a row starts the mean, variance and 32-step square
// root, then the results one by one, each through the 49-step shared
// divider unless the root is zero. Input is stalled meanwhile.
// Reset sets scale to 1.0 and shift to 0 through per-entry valid bits.
// A stalled result beat holds in the output register.
module layer_normalization_row (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lnr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lnr_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [lnr_pkg::ADDR_W-1:0]          entry_index,
    input  logic signed [lnr_pkg::DATA_W-1:0]   sample_value,
    input  logic signed [lnr_pkg::DATA_W-1:0]   scale_value,
    input  logic signed [lnr_pkg::DATA_W-1:0]   shift_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lnr_pkg::DATA_W-1:0]   normalized_value,
    output logic [lnr_pkg::ADDR_W-1:0]          position,
    output logic                                row_end
);
    import lnr_pkg::*;

    // Configuration
    logic [LEN_W-1:0]          row_length_reg;
    logic [CFG_W-1:0]          epsilon_reg;
    logic [LEN_W-1:0]          eff_len;

    // Memories
    logic signed [DATA_W-1:0]  row_buffer [MAX_LEN];
    logic [2*DATA_W-1:0]       coef_mem [MAX_LEN];
    logic [MAX_LEN-1:0]        coef_valid_reg;
    logic signed [DATA_W-1:0]  rb_rd_reg;
    logic [2*DATA_W-1:0]       coef_rd_reg;
    logic                      coef_vld_rd_reg;

    // Sequencer and datapath
    lnr_state_t                state_reg, state_next;
    logic [LEN_W-1:0]          fill_reg, fill_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [LEN_W-1:0]          j_reg, j_next;
    logic [1:0]                step2_reg, step2_next;
    logic [4:0]                sq_step_reg, sq_step_next;
    logic signed [21:0]        sum_reg, sum_next;
    logic signed [23:0]        d_reg, d_next;
    logic [47:0]               prod_reg, prod_next;
    logic [63:0]               acc_reg, acc_next;
    logic [36:0]               t_reg, t_next;
    logic [63:0]               rad_reg, rad_next;
    logic [SQRT_W-1:0]         root_reg, root_next;
    logic [35:0]               rem_reg, rem_next;
    logic signed [DATA_W-1:0]  sc_reg, sc_next;
    logic signed [DATA_W-1:0]  sh_reg, sh_next;
    logic signed [31:0]        p_reg, p_next;
    logic signed [47:0]        num_reg, num_next;
    logic [DIV_W-1:0]          dvd_reg, dvd_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  out_val_reg, out_val_next;
    logic [ADDR_W-1:0]         out_pos_reg, out_pos_next;
    logic                      out_end_reg, out_end_next;

    // Combinational helpers
    logic                      in_acc;
    logic                      rb_we, coef_we;
    logic [ADDR_W-1:0]         rb_waddr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [LEN_W-1:0]          fill_inc;
    logic signed [23:0]        lx;
    logic [35:0]               rem_sh, trial;
    logic [47:0]               mag;
    logic [63:0]               ql;
    logic                      div_start, div_done;
    logic [DIV_W-1:0]          quo;
    logic [DIV_W-1:0]          q_use;
    logic signed [50:0]        v;
    logic                      out_free;

    assign eff_len = (row_length_reg == '0) ? LEN_W'(1) :
                     (row_length_reg > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : row_length_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_addr  = j_reg[ADDR_W-1:0];
    assign fill_inc = fill_reg + LEN_W'(1);
    assign rb_waddr = fill_reg[ADDR_W-1:0];
    assign rb_we    = in_acc && (command == CMD_SAMPLE);
    assign coef_we  = in_acc && (command == CMD_ENTRY);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= LEN_W'(MAX_LEN);
            epsilon_reg    <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_LENGTH: row_length_reg <= cfg_data[LEN_W-1:0];
                CFG_EPSILON:    epsilon_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Row buffer and coefficient store
    always_ff @(posedge clk)
    begin
        if (rb_we)
            row_buffer[rb_waddr] <= sample_value;
        if (coef_we)
            coef_mem[entry_index] <= {scale_value, shift_value};
        rb_rd_reg   <= row_buffer[rd_addr];
        coef_rd_reg <= coef_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg  <= '0;
            coef_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (coef_we)
                coef_valid_reg[entry_index] <= 1'b1;
            coef_vld_rd_reg <= coef_valid_reg[rd_addr];
        end
    end

    // Shared divider
    lnr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (root_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        j_next         = j_reg;
        step2_next     = step2_reg;
        sq_step_next   = sq_step_reg;
        sum_next       = sum_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        t_next         = t_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        sc_next        = sc_reg;
        sh_next        = sh_reg;
        p_next         = p_reg;
        num_next       = num_reg;
        dvd_next       = dvd_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_val_next   = out_val_reg;
        out_pos_next   = out_pos_reg;
        out_end_next   = out_end_reg;
        div_start      = 1'b0;

        lx     = $signed({1'b0, len_reg}) * rb_rd_reg;
        rem_sh = {rem_reg[33:0], rad_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        mag    = num_reg[47] ? 48'(-num_reg) : 48'(num_reg);
        ql     = 64'(acc_reg * len_reg);
        q_use  = (root_reg == '0) ? '0 : quo;
        v      = (num_reg[47] ? -$signed({2'b00, q_use}) : $signed({2'b00, q_use}))
                 + 51'(sh_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rb_we)
                begin
                    if (fill_inc >= eff_len)
                    begin
                        fill_next  = '0;
                        len_next   = eff_len;
                        j_next     = '0;
                        sum_next   = '0;
                        acc_next   = '0;
                        state_next = ST_SUM_RD;
                    end
                    else
                        fill_next = fill_inc;
                end
            end
            ST_SUM_RD:
                state_next = ST_SUM_ACC;
            ST_SUM_ACC:
            begin
                sum_next = sum_reg + 22'(rb_rd_reg);
                if (j_reg + LEN_W'(1) == len_reg)
                begin
                    j_next     = '0;
                    state_next = ST_VAR_RD;
                end
                else
                begin
                    j_next     = j_reg + LEN_W'(1);
                    state_next = ST_SUM_RD;
                end
            end
            ST_VAR_RD:
                state_next = ST_VAR_D;
            ST_VAR_D:
            begin
                d_next     = lx - 24'(sum_reg);
                state_next = ST_VAR_SQ;
            end
            ST_VAR_SQ:
            begin
                prod_next  = 48'(d_reg * d_reg);
                state_next = ST_VAR_ACC;
            end
            ST_VAR_ACC:
            begin
                acc_next = acc_reg + 64'(prod_reg);
                if (j_reg + LEN_W'(1) == len_reg)
                begin
                    j_next     = '0;
                    t_next     = 37'(epsilon_reg);
                    step2_next = '0;
                    state_next = ST_EPS;
                end
                else
                begin
                    j_next     = j_reg + LEN_W'(1);
                    state_next = ST_VAR_RD;
                end
            end
            ST_EPS:
            begin
                // epsilon times length cubed, one multiply per cycle
                t_next     = 37'(t_reg * len_reg);
                step2_next = step2_reg + 2'd1;
                if (step2_reg == 2'd2)
                    state_next = ST_QADD;
            end
            ST_QADD:
            begin
                acc_next   = acc_reg + 64'(t_reg);
                state_next = ST_QL;
            end
            ST_QL:
            begin
                rad_next     = {ql[55:0], 8'b0};
                root_next    = '0;
                rem_next     = '0;
                sq_step_next = '0;
                state_next   = ST_SQRT;
            end
            ST_SQRT:
            begin
                // one root bit per cycle
                rad_next = {rad_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[SQRT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[SQRT_W-2:0], 1'b0};
                end
                sq_step_next = sq_step_reg + 5'd1;
                if (sq_step_reg == 5'd31)
                    state_next = ST_OUT_RD;
            end
            ST_OUT_RD:
                state_next = ST_OUT_D;
            ST_OUT_D:
            begin
                d_next     = lx - 24'(sum_reg);
                sc_next    = coef_vld_rd_reg ? coef_rd_reg[2*DATA_W-1:DATA_W] : SCALE_ONE;
                sh_next    = coef_vld_rd_reg ? coef_rd_reg[DATA_W-1:0] : '0;
                state_next = ST_OUT_M1;
            end
            ST_OUT_M1:
            begin
                p_next     = d_reg * $signed({1'b0, len_reg});
                state_next = ST_OUT_M2;
            end
            ST_OUT_M2:
            begin
                num_next   = p_reg * sc_reg;
                state_next = ST_OUT_PREP;
            end
            ST_OUT_PREP:
            begin
                // round half away from zero: add half the divisor to the magnitude
                dvd_next   = {mag[44:0], 4'b0} + DIV_W'(root_reg[SQRT_W-1:1]);
                state_next = (root_reg == '0) ? ST_OUT_PUT : ST_OUT_GO;
            end
            ST_OUT_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (div_done)
                    state_next = ST_OUT_PUT;
            end
            ST_OUT_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (v > 51'sd32767)
                        out_val_next = 16'sh7FFF;
                    else if (v < -51'sd32768)
                        out_val_next = 16'sh8000;
                    else
                        out_val_next = v[DATA_W-1:0];
                    out_pos_next = j_reg[ADDR_W-1:0];
                    out_end_next = (j_reg + LEN_W'(1) == len_reg);
                    if (j_reg + LEN_W'(1) == len_reg)
                    begin
                        j_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + LEN_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            j_reg         <= '0;
            step2_reg     <= '0;
            sq_step_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            j_reg         <= j_next;
            step2_reg     <= step2_next;
            sq_step_reg   <= sq_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        sum_reg     <= sum_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        t_reg       <= t_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        sc_reg      <= sc_next;
        sh_reg      <= sh_next;
        p_reg       <= p_next;
        num_reg     <= num_next;
        dvd_reg     <= dvd_next;
        out_val_reg <= out_val_next;
        out_pos_reg <= out_pos_next;
        out_end_reg <= out_end_next;
    end

    assign out_valid        = out_valid_reg;
    assign normalized_value = out_val_reg;
    assign position         = out_pos_reg;
    assign row_end          = out_end_reg;

endmodule

/* src/lnr_div.sv */
// Restoring divider: one quotient bit per cycle.
module lnr_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lnr_pkg::DIV_W-1:0]      dividend,
    input  logic [lnr_pkg::SQRT_W-1:0]     divisor,
    output logic                           done,
    output logic [lnr_pkg::DIV_W-1:0]      quotient
);
    import lnr_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [SQRT_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [SQRT_W-1:0]   dvs_reg, dvs_next;
    logic [SQRT_W:0]     rem_sh;

    // Shift in one dividend bit and try one subtract per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = SQRT_W'(rem_sh - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[SQRT_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* test/layer_normalization_row_test.sv */
// Self-checking testbench for the row layer normalization block.
`timescale 1ns / 100ps

module layer_normalization_row_test;
    import lnr_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [ADDR_W-1:0]        pos;
        logic                     last;
    } norm_beat_t;

    // Scoreboard: predicts each normalized row and checks result beats in order
    class norm_scoreboard;
        logic signed [DATA_W-1:0] samples [MAX_LEN];
        logic signed [DATA_W-1:0] gains [MAX_LEN];
        logic signed [DATA_W-1:0] offsets [MAX_LEN];
        int unsigned              filled;
        int unsigned              len_reg;
        int unsigned              eps_reg;
        norm_beat_t               pending_beats [$];
        int                       errors;

        function new();
            for (int i = 0; i < MAX_LEN; i++)
            begin
                samples[i] = '0;
                gains[i]   = SCALE_ONE;
                offsets[i] = '0;
            end
            filled  = 0;
            len_reg = 64;
            eps_reg = 1;
            errors  = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_ROW_LENGTH)
                len_reg = value[LEN_W-1:0];
            else
                eps_reg = value;
        endfunction

        static function bit [63:0] int_root(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // Store a sample or table entry; on row completion queue the whole row
        function void note_item(logic cmd, logic [ADDR_W-1:0] idx,
                                logic signed [DATA_W-1:0] smp,
                                logic signed [DATA_W-1:0] gain,
                                logic signed [DATA_W-1:0] offset);
            int unsigned len;
            longint      total;
            longint      d;
            longint      num;
            longint      v;
            bit [63:0]   sumsq;
            bit [63:0]   q;
            bit [63:0]   root;
            bit [63:0]   mag;
            bit [63:0]   r;
            norm_beat_t  nb;
            if (cmd == CMD_ENTRY)
            begin
                gains[idx]   = gain;
                offsets[idx] = offset;
                return;
            end
            if (filled >= MAX_LEN)
                filled = 0;
            samples[filled] = smp;
            filled++;
            len = len_reg;
            if (len == 0)
                len = 1;
            if (len > MAX_LEN)
                len = MAX_LEN;
            if (filled < len)
                return;
            filled = 0;
            total = 0;
            for (int j = 0; j < len; j++)
                total += longint'(samples[j]);
            sumsq = 0;
            for (int j = 0; j < len; j++)
            begin
                d = longint'(len) * longint'(samples[j]) - total;
                sumsq += d * d;
            end
            q = sumsq + longint'(eps_reg) * len * len * len;
            root = int_root(q * len * 256);
            for (int j = 0; j < len; j++)
            begin
                d = longint'(len) * longint'(samples[j]) - total;
                num = d * longint'(len) * longint'(gains[j]) * 16;
                v = 0;
                if (root != 0)
                begin
                    mag = (num < 0) ? -num : num;
                    r = (mag + root / 2) / root;
                    v = (num < 0) ? -longint'(r) : longint'(r);
                end
                v += longint'(offsets[j]);
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                nb.value = v[DATA_W-1:0];
                nb.pos   = j[ADDR_W-1:0];
                nb.last  = (j == len - 1);
                pending_beats.push_back(nb);
            end
        endfunction

        function void check_beat(logic signed [DATA_W-1:0] value,
                                 logic [ADDR_W-1:0] pos, logic last);
            norm_beat_t want;
            if (pending_beats.size() == 0)
            begin
                report($sformatf("unexpected beat value %0d pos %0d", value, pos));
                return;
            end
            want = pending_beats.pop_front();
            if (value !== want.value)
                report($sformatf("pos %0d value %0d, want %0d", want.pos, value, want.value));
            if (pos !== want.pos)
                report($sformatf("position %0d, want %0d", pos, want.pos));
            if (last !== want.last)
                report($sformatf("pos %0d row_end %0b, want %0b", want.pos, last, want.last));
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic                        command;
    logic [ADDR_W-1:0]           entry_index;
    logic signed [DATA_W-1:0]    sample_value;
    logic signed [DATA_W-1:0]    scale_value;
    logic signed [DATA_W-1:0]    shift_value;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    normalized_value;
    logic [ADDR_W-1:0]           position;
    logic                        row_end;

    norm_scoreboard sb = new();
    int unsigned    send_pct;
    int unsigned    stall_pct;
    bit             hold_go;
    int unsigned    quiet_cycles;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2500;

    layer_normalization_row dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .entry_index      (entry_index),
        .sample_value     (sample_value),
        .scale_value      (scale_value),
        .shift_value      (shift_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .normalized_value (normalized_value),
        .position         (position),
        .row_end          (row_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(normalized_value, position, row_end);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("layer_normalization_row_test NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stall, or a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        sb.configure(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offer one beat, with a random gap first, and hold it until accepted
    task automatic send_beat(logic cmd, logic [ADDR_W-1:0] idx,
                             logic signed [DATA_W-1:0] smp,
                             logic signed [DATA_W-1:0] gain,
                             logic signed [DATA_W-1:0] offset);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        command      = cmd;
        entry_index  = idx;
        sample_value = smp;
        scale_value  = gain;
        shift_value  = offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(cmd, idx, smp, gain, offset);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_sample(logic signed [DATA_W-1:0] smp);
        send_beat(CMD_SAMPLE, 6'($urandom), smp, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_entry(logic [ADDR_W-1:0] idx, logic signed [DATA_W-1:0] gain,
                              logic signed [DATA_W-1:0] offset);
        send_beat(CMD_ENTRY, idx, 16'($urandom), gain, offset);
    endtask

    // Drop valid and wait until every expected beat is out, then let the block settle
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending_beats.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2, 3: return $signed(16'($urandom_range(1024))) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random phase: mostly samples, some table writes
    task automatic random_phase(int unsigned count);
        logic signed [DATA_W-1:0] gain;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
            begin
                if ($urandom_range(3) == 0)
                    gain = 16'($urandom);
                else
                    gain = $signed(16'($urandom_range(1024))) - 16'sd512;
                send_entry(6'($urandom), gain, 16'($urandom));
            end
            else
                send_sample(pick_sample());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        command      = CMD_SAMPLE;
        entry_index  = '0;
        sample_value = '0;
        scale_value  = '0;
        shift_value  = '0;
        send_pct     = 0;
        stall_pct    = 0;
        hold_go      = 1'b0;
        quiet_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: default table, extremes, short rows
        write_reg(CFG_ROW_LENGTH, 16'd4);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_entry(6'd63, -16'sd32768, 16'sd32767);
        send_entry(6'd0, 16'sd32767, -16'sd32768);
        send_entry(6'd1, 16'sd0, 16'sd100);
        send_sample(16'sd256);
        send_sample(-16'sd256);
        send_sample(16'sd512);
        send_sample(16'sd0);
        drain();

        // Zero variance with zero epsilon: results equal the shifts
        write_reg(CFG_EPSILON, 16'd0);
        write_reg(CFG_ROW_LENGTH, 16'd3);
        repeat (3) send_sample(16'sd77);
        drain();

        // Zero row length acts as one; then lower the length mid-row
        write_reg(CFG_ROW_LENGTH, 16'd0);
        send_sample(16'sd1000);
        drain();
        write_reg(CFG_ROW_LENGTH, 16'd8);
        write_reg(CFG_EPSILON, 16'd65535);
        repeat (5) send_sample(pick_sample());
        drain();
        write_reg(CFG_ROW_LENGTH, 16'd3);
        send_sample(pick_sample());
        drain();

        // No idling, with a long receiver hold-off while the sender keeps going
        write_reg(CFG_ROW_LENGTH, 16'd5);
        write_reg(CFG_EPSILON, 16'd1);
        hold_go = 1'b1;
        random_phase(12);
        drain();
        random_phase(8);
        // Pause the sender until every row has come out
        drain();

        // Sender idle about half the time
        send_pct = 52;
        write_reg(CFG_ROW_LENGTH, 16'd2);
        write_reg(CFG_EPSILON, 16'd0);
        random_phase(20);
        drain();

        // Receiver stalling; length above the maximum acts as a full row
        send_pct  = 0;
        stall_pct = 52;
        write_reg(CFG_ROW_LENGTH, 16'd127);
        write_reg(CFG_EPSILON, 16'd65535);
        for (int i = 0; i < 64; i++)
            send_sample(pick_sample());
        drain();

        // Both sides idle a little
        send_pct  = 7;
        stall_pct = 7;
        write_reg(CFG_ROW_LENGTH, 16'd7);
        write_reg(CFG_EPSILON, 16'd50);
        random_phase(10);
        drain();
        send_pct  = 0;
        stall_pct = 0;
        repeat (100) @(negedge clk);

        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("layer_normalization_row_test OK");
        else
            $display("layer_normalization_row_test NOT OK");
        $finish;
    end

endmodule
